[sv/text_console_character_writer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the text console character writer
// Clocked concurrent checks, with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_ASSERT_SVH

// check disabled while rstn is low
`define TCW_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: check failed");

// check that also runs through reset
`define TCW_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");

`endif

[sv/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, character codes, cell constants and types of the console
// character writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int CH_W       = 8;
  localparam int ADDR_IN_W  = 11;
  localparam int COL_OUT_W  = 7;
  localparam int ROW_OUT_W  = 5;
  localparam int DATA_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int TAB_STEP   = 8;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CH_W-1:0] CH_BS       = 8'h08;
  localparam logic [CH_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CH_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CH_W-1:0] PRINT_FIRST = 8'h20;
  localparam logic [CH_W-1:0] PRINT_LAST  = 8'h7F;
  localparam logic [CH_W-1:0] SPACE_CHAR  = 8'h20;

  localparam logic [DATA_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [DATA_W-1:0] ATTR_MASK  = 16'hFF00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_SCROLL = 3'd4
  } tcw_reg_t;

  typedef struct packed {
    logic printable;
    logic bottom;
  } tcw_move_t;

endpackage

[sv/tcw_if.sv]
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels for the request items and the result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcw_in_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [CH_W-1:0]      character;
  logic [ADDR_IN_W-1:0] cell_address;

  modport source (output valid, output operation, output character, output cell_address,
                  input ready);
  modport sink (input valid, input operation, input character, input cell_address,
                output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COL_OUT_W-1:0] cursor_column;
  logic [ROW_OUT_W-1:0] cursor_line;
  logic                 did_scroll;
  logic [DATA_W-1:0]    cell_data;

  modport source (output valid, output cursor_column, output cursor_line,
                  output did_scroll, output cell_data, input ready);
  modport sink (input valid, input cursor_column, input cursor_line,
                input did_scroll, input cell_data, output ready);
endinterface

[sv/tcw_cell_ram.sv]
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_cell_ram import tcw_pkg::*; #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/tcw_cursor.sv]
// ----------------------------------------------------------------------------
// tcw_cursor
// Next cursor position for one byte: control codes, advance, right-edge wrap
// and bottom clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_cursor import tcw_pkg::*; #(
  parameter int COL_W = 7,
  parameter int ROW_W = 5
) (
  input  logic [COL_W-1:0] col,
  input  logic [ROW_W-1:0] row,
  input  logic [CH_W-1:0]  ch,
  input  logic [COL_W-1:0] left,
  input  logic [COL_W-1:0] right,
  input  logic [ROW_W-1:0] top,
  input  logic [ROW_W-1:0] bottom,
  output logic [COL_W-1:0] nxt_col,
  output logic [ROW_W-1:0] nxt_row,
  output tcw_move_t        move
);

  logic [COL_W-1:0] c;
  logic [ROW_W-1:0] r;

  always_comb begin
    c = col;
    r = row;
    move = '0;
    priority if (ch == CH_BS) begin
      if (c > left) begin
        c = c - COL_W'(1);
      end else begin
        c = right - COL_W'(1);
        if (r > top) begin
          r = r - ROW_W'(1);
        end
      end
    end else if (ch == CH_CR) begin
      c = left;
    end else if (ch == CH_LF) begin
      c = left;
      r = r + ROW_W'(1);
    end else if (ch == CH_TAB) begin
      c = (c | COL_W'(TAB_STEP - 1)) + COL_W'(1);
    end else if (ch >= PRINT_FIRST && ch <= PRINT_LAST) begin
      move.printable = 1'b1;
      c = c + COL_W'(1);
    end else begin
      c = col;
    end
    if (c >= right) begin
      c = left;
      r = r + ROW_W'(1);
    end
    if (r >= bottom) begin
      move.bottom = 1'b1;
      r = bottom - ROW_W'(1);
    end
    nxt_col = c;
    nxt_row = r;
  end

endmodule

[sv/tcw_seq.sv]
// ----------------------------------------------------------------------------
// tcw_seq
// Sequencer around the cell store: clearing pass, cell reads, character
// read-modify-write, region scroll copy and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_seq import tcw_pkg::*; #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25,
  parameter int COL_W          = $clog2(SCREEN_COLUMNS + TAB_STEP),
  parameter int ROW_W          = $clog2(SCREEN_ROWS + 1),
  parameter int AW             = $clog2(SCREEN_COLUMNS * SCREEN_ROWS)
) (
  input  logic              clk,
  input  logic              rst_n,
  tcw_in_if.sink            in_item,
  tcw_out_if.source         out_item,
  input  logic [COL_W-1:0]  left_e,
  input  logic [COL_W-1:0]  right_e,
  input  logic [ROW_W-1:0]  top_e,
  input  logic [ROW_W-1:0]  bottom_e,
  input  logic              scroll_en,
  input  logic              home_req,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [DATA_W-1:0] ram_wdata,
  output logic [AW-1:0]     ram_raddr,
  input  logic [DATA_W-1:0] ram_rdata
);

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int AXW   = ((ADDR_IN_W > AW) ? ADDR_IN_W : AW) + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_PUT,
    S_SCROLL,
    S_DRAIN
  } state_t;

  state_t               state_r;
  logic [AW-1:0]        clr_r;
  logic [COL_W-1:0]     col_r;
  logic [ROW_W-1:0]     row_r;
  logic [AW-1:0]        idx_r;
  logic [CH_W-1:0]      ch_r;
  logic                 inrange_r;
  logic                 scroll_pend_r;
  logic [COL_W-1:0]     sc_col_r;
  logic [ROW_W-1:0]     sc_row_r;
  logic                 pend_r;
  logic [AW-1:0]        pend_addr_r;
  logic                 pend_last_r;
  logic                 out_valid_r;
  logic [COL_OUT_W-1:0] out_col_r;
  logic [ROW_OUT_W-1:0] out_row_r;
  logic                 out_scroll_r;
  logic [DATA_W-1:0]    out_data_r;

  logic                 rdy;
  logic                 in_acc;
  logic                 is_read;
  logic                 rd_ok;
  logic                 do_scroll;
  logic                 sc_last;
  logic                 sc_col_end;
  logic [ROW_W-1:0]     sc_src_row;
  logic [COL_W-1:0]     mv_col;
  logic [ROW_W-1:0]     mv_row;
  tcw_move_t            mv;

  function automatic logic [AW-1:0] cell_idx(input logic [ROW_W-1:0] r,
                                             input logic [COL_W-1:0] c);
    logic [AW-1:0] r_x;
    logic [AW-1:0] c_x;
    r_x = AW'(r);
    c_x = AW'(c);
    return AW'(r_x * AW'(SCREEN_COLUMNS)) + c_x;
  endfunction

  tcw_cursor #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_cursor (
    .col     (col_r),
    .row     (row_r),
    .ch      (in_item.character),
    .left    (left_e),
    .right   (right_e),
    .top     (top_e),
    .bottom  (bottom_e),
    .nxt_col (mv_col),
    .nxt_row (mv_row),
    .move    (mv)
  );

  assign rdy        = (state_r == S_IDLE) && !home_req && (!out_valid_r || out_item.ready);
  assign in_acc     = in_item.valid && rdy;
  assign is_read    = (in_item.operation == OP_READ);
  assign rd_ok      = AXW'(in_item.cell_address) < AXW'(CELLS);
  assign do_scroll  = mv.bottom && scroll_en;
  assign sc_last    = (sc_row_r == (bottom_e - ROW_W'(1)));
  assign sc_col_end = (sc_col_r == (right_e - COL_W'(1)));
  assign sc_src_row = sc_last ? sc_row_r : (sc_row_r + ROW_W'(1));

  assign in_item.ready          = rdy;
  assign out_item.valid         = out_valid_r;
  assign out_item.cursor_column = out_col_r;
  assign out_item.cursor_line   = out_row_r;
  assign out_item.did_scroll    = out_scroll_r;
  assign out_item.cell_data     = out_data_r;

  always_comb begin
    ram_raddr = cell_idx(row_r, col_r);
    if (state_r == S_SCROLL) begin
      ram_raddr = cell_idx(sc_src_row, sc_col_r);
    end else if (is_read) begin
      ram_raddr = AW'(in_item.cell_address);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr_r;
    ram_wdata = ram_rdata;
    priority if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = BLANK_CELL;
    end else if (pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r;
      ram_wdata = pend_last_r ? ((ram_rdata & ATTR_MASK) | DATA_W'(SPACE_CHAR)) : ram_rdata;
    end else if (state_r == S_PUT) begin
      ram_we    = 1'b1;
      ram_waddr = idx_r;
      ram_wdata = (ram_rdata & ATTR_MASK) | DATA_W'(ch_r);
    end else begin
      ram_we    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= 1'b0;
      if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (is_read) begin
              inrange_r <= rd_ok;
              state_r   <= S_READ;
            end else begin
              col_r <= mv_col;
              row_r <= mv_row;
              if (mv.printable) begin
                idx_r         <= cell_idx(row_r, col_r);
                ch_r          <= in_item.character;
                scroll_pend_r <= do_scroll;
                state_r       <= S_PUT;
              end else if (do_scroll) begin
                sc_row_r <= top_e;
                sc_col_r <= left_e;
                state_r  <= S_SCROLL;
              end else begin
                out_valid_r  <= 1'b1;
                out_col_r    <= COL_OUT_W'(mv_col);
                out_row_r    <= ROW_OUT_W'(mv_row);
                out_scroll_r <= 1'b0;
                out_data_r   <= '0;
              end
            end
          end
        end
        S_READ: begin
          out_valid_r  <= 1'b1;
          out_col_r    <= COL_OUT_W'(col_r);
          out_row_r    <= ROW_OUT_W'(row_r);
          out_scroll_r <= 1'b0;
          out_data_r   <= inrange_r ? ram_rdata : '0;
          state_r      <= S_IDLE;
        end
        S_PUT: begin
          if (scroll_pend_r) begin
            sc_row_r <= top_e;
            sc_col_r <= left_e;
            state_r  <= S_SCROLL;
          end else begin
            out_valid_r  <= 1'b1;
            out_col_r    <= COL_OUT_W'(col_r);
            out_row_r    <= ROW_OUT_W'(row_r);
            out_scroll_r <= 1'b0;
            out_data_r   <= '0;
            state_r      <= S_IDLE;
          end
        end
        S_SCROLL: begin
          // read the cell below, write it back one row up next cycle; the last row gets spaces
          pend_r      <= 1'b1;
          pend_addr_r <= cell_idx(sc_row_r, sc_col_r);
          pend_last_r <= sc_last;
          if (sc_col_end) begin
            sc_col_r <= left_e;
            if (sc_last) begin
              state_r <= S_DRAIN;
            end else begin
              sc_row_r <= sc_row_r + ROW_W'(1);
            end
          end else begin
            sc_col_r <= sc_col_r + COL_W'(1);
          end
        end
        S_DRAIN: begin
          out_valid_r  <= 1'b1;
          out_col_r    <= COL_OUT_W'(col_r);
          out_row_r    <= ROW_OUT_W'(row_r);
          out_scroll_r <= 1'b1;
          out_data_r   <= '0;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (home_req) begin
        col_r <= left_e;
        row_r <= top_e;
      end
    end
  end

endmodule

[sv/text_console_character_writer.sv]
// Put of a printable byte: a read-modify-write of one cell through the store ports.
// Cell read: a registered read of the store.
// A scroll copies one region cell per cycle on the single port pair.
// After reset a clearing pass writes SCREEN_COLUMNS*SCREEN_ROWS cells (2000) before
// the first item; register writes are taken during it. A region write homes the cursor
// through a registered home request.
// ----------------------------------------------------------------------------
// text_console_character_writer
// Text-mode console writer: draw region registers, cursor and cell store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_character_writer import tcw_pkg::*; #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tcw_in_if.sink                in_item,
  tcw_out_if.source             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int COL_W = $clog2(SCREEN_COLUMNS + TAB_STEP);
  localparam int ROW_W = $clog2(SCREEN_ROWS + 1);
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = (COL_W > COL_OUT_W) ? COL_W : COL_OUT_W;
  localparam int RW    = (ROW_W > ROW_OUT_W) ? ROW_W : ROW_OUT_W;
  localparam logic [COL_OUT_W-1:0] WIDTH_RST  =
    COL_OUT_W'((SCREEN_COLUMNS > 127) ? 127 : SCREEN_COLUMNS);
  localparam logic [ROW_OUT_W-1:0] HEIGHT_RST =
    ROW_OUT_W'((SCREEN_ROWS > 31) ? 31 : SCREEN_ROWS);

  logic [COL_OUT_W-1:0] left_r;
  logic [ROW_OUT_W-1:0] top_r;
  logic [COL_OUT_W-1:0] width_r;
  logic [ROW_OUT_W-1:0] height_r;
  logic                 scroll_r;
  logic                 home_r;

  logic [CW-1:0]        left_x;
  logic [CW-1:0]        room_x;
  logic [CW-1:0]        w_x;
  logic [CW-1:0]        right_x;
  logic [RW-1:0]        top_x;
  logic [RW-1:0]        hroom_x;
  logic [RW-1:0]        h_x;
  logic [RW-1:0]        bottom_x;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [DATA_W-1:0]    ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [DATA_W-1:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      scroll_r <= 1'b0;
      home_r   <= 1'b0;
    end else begin
      home_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LEFT: begin
            left_r <= cfg_data;
            home_r <= 1'b1;
          end
          REG_TOP: begin
            top_r  <= cfg_data[ROW_OUT_W-1:0];
            home_r <= 1'b1;
          end
          REG_WIDTH: begin
            width_r <= cfg_data;
            home_r  <= 1'b1;
          end
          REG_HEIGHT: begin
            height_r <= cfg_data[ROW_OUT_W-1:0];
            home_r   <= 1'b1;
          end
          REG_SCROLL: begin
            scroll_r <= cfg_data[0];
          end
          default: begin
            home_r <= 1'b0;
          end
        endcase
      end
    end
  end

  // region clamped to the screen
  always_comb begin
    left_x = CW'(left_r);
    if (left_x > CW'(SCREEN_COLUMNS - 1)) begin
      left_x = CW'(SCREEN_COLUMNS - 1);
    end
    room_x = CW'(SCREEN_COLUMNS) - left_x;
    if (width_r == '0) begin
      w_x = CW'(1);
    end else if (CW'(width_r) > room_x) begin
      w_x = room_x;
    end else begin
      w_x = CW'(width_r);
    end
    right_x = left_x + w_x;

    top_x = RW'(top_r);
    if (top_x > RW'(SCREEN_ROWS - 1)) begin
      top_x = RW'(SCREEN_ROWS - 1);
    end
    hroom_x = RW'(SCREEN_ROWS) - top_x;
    if (height_r == '0) begin
      h_x = RW'(1);
    end else if (RW'(height_r) > hroom_x) begin
      h_x = hroom_x;
    end else begin
      h_x = RW'(height_r);
    end
    bottom_x = top_x + h_x;
  end

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_seq #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .COL_W          (COL_W),
    .ROW_W          (ROW_W),
    .AW             (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_item  (out_item),
    .left_e    (COL_W'(left_x)),
    .right_e   (COL_W'(right_x)),
    .top_e     (ROW_W'(top_x)),
    .bottom_e  (ROW_W'(bottom_x)),
    .scroll_en (scroll_r),
    .home_req  (home_r),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

[sv/tcw_port_checker.sv]
// ----------------------------------------------------------------------------
// tcw_port_checker
// Port-level checks of the console writer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_character_writer_assert.svh"

module tcw_port_checker import tcw_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  tcw_in_if.sink              in_item,
  tcw_out_if.source           out_item,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index
);

  // clearing pass holds off items
  `TCW_ASSERT_NORST(a_reset_holds_input, clk, !rst_n |=> !in_item.ready)

  // region write homes the cursor before the next item
  `TCW_ASSERT(a_home_blocks_input, clk, rst_n, cfg_we && (cfg_index == REG_LEFT || cfg_index == REG_TOP || cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT) |=> !in_item.ready)

  // reads and printable puts hold off the next item while they use the store port
  `TCW_ASSERT(a_rmw_blocks_input, clk, rst_n, in_item.valid && in_item.ready && (in_item.operation == OP_READ || (in_item.character >= PRINT_FIRST && in_item.character <= PRINT_LAST)) |=> !in_item.ready)

  `TCW_ASSERT(a_out_held, clk, rst_n, out_item.valid && !out_item.ready |=> out_item.valid && $stable(out_item.cell_data) && $stable(out_item.cursor_column))

endmodule

bind text_console_character_writer tcw_port_checker u_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_item   (in_item),
  .out_item  (out_item),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index)
);

[verif/tb_text_console_character_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_character_writer
// Self-checking bench for the console character writer. A directed table of
// requests and region settings runs first, then random phases, each with its
// own draw region. Every accepted request is run through a local copy of the
// cell store, cursor and region logic. Each result item is checked field by
// field against the oldest expectation. Bursty requests, a stalling result
// side and one long result hold-off that backs the block up.
// ----------------------------------------------------------------------------

module tb_text_console_character_writer;
  import tcw_pkg::*;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_LINES = 25;
  localparam int CELL_COUNT = SCREEN_COLS * SCREEN_LINES;
  localparam int PHASE_COUNT = 12;
  localparam int PHASE_ITEMS = 127;
  localparam int PRESSURE_AFTER = 200;

  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
    logic                 scrolled;
    logic [DATA_W-1:0]    data;
  } console_result_t;

  typedef struct {
    int left;
    int top;
    int w;
    int h;
  } region_t;

  typedef enum {ROW_ITEM, ROW_REGS} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic                  op;
    logic [CH_W-1:0]       ch;
    logic [ADDR_IN_W-1:0]  addr;
    logic                  known;
    console_result_t       want;
    logic [CFG_DATA_W-1:0] left;
    logic [CFG_DATA_W-1:0] top;
    logic [CFG_DATA_W-1:0] width;
    logic [CFG_DATA_W-1:0] height;
    logic                  scroll;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tcw_in_if  in_ch();
  tcw_out_if out_ch();

  text_console_character_writer #(
    .SCREEN_COLUMNS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_LINES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_item(in_ch),
    .out_item(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // local copy of the console state
  logic [DATA_W-1:0] screen_cells [0:CELL_COUNT-1];
  int                cur_col;
  int                cur_row;
  logic [6:0]        reg_left;
  logic [4:0]        reg_top;
  logic [6:0]        reg_width;
  logic [4:0]        reg_height;
  logic              reg_scroll;

  console_result_t console_results_q [$];
  stim_row_t       stim_table [$];
  int              error_count = 0;
  int              results_seen = 0;
  int              burst_left = 0;
  logic            typed_pending = 1'b0;
  console_result_t typed_want = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("simulation failed");
    $finish;
  end

  function automatic void reset_console();
    for (int i = 0; i < CELL_COUNT; i++) screen_cells[i] = BLANK_CELL;
    reg_left = '0;
    reg_top = '0;
    reg_width = 7'(SCREEN_COLS);
    reg_height = 5'(SCREEN_LINES);
    reg_scroll = 1'b0;
    cur_col = 0;
    cur_row = 0;
  endfunction

  function automatic region_t active_region();
    region_t rg;
    int room;
    rg.left = (reg_left > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : int'(reg_left);
    rg.top = (reg_top > SCREEN_LINES - 1) ? SCREEN_LINES - 1 : int'(reg_top);
    room = SCREEN_COLS - rg.left;
    rg.w = (reg_width == 0) ? 1 : ((reg_width > room) ? room : int'(reg_width));
    room = SCREEN_LINES - rg.top;
    rg.h = (reg_height == 0) ? 1 : ((reg_height > room) ? room : int'(reg_height));
    return rg;
  endfunction

  function automatic void write_console_reg(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
    region_t rg;
    case (tcw_reg_t'(idx))
      REG_LEFT:   reg_left = val;
      REG_TOP:    reg_top = val[4:0];
      REG_WIDTH:  reg_width = val;
      REG_HEIGHT: reg_height = val[4:0];
      REG_SCROLL: reg_scroll = val[0];
      default: ;
    endcase
    if (tcw_reg_t'(idx) inside {REG_LEFT, REG_TOP, REG_WIDTH, REG_HEIGHT}) begin
      rg = active_region();
      cur_col = rg.left;
      cur_row = rg.top;
    end
  endfunction

  function automatic console_result_t advance_console(logic op, logic [CH_W-1:0] ch,
                                                      logic [ADDR_IN_W-1:0] addr);
    region_t rg;
    console_result_t res;
    int idx;
    rg = active_region();
    res = '0;
    if (op == OP_READ) begin
      if (addr < CELL_COUNT) res.data = screen_cells[addr];
    end else begin
      if (ch == CH_BS) begin
        if (cur_col > rg.left) begin
          cur_col--;
        end else begin
          cur_col = rg.left + rg.w - 1;
          if (cur_row > rg.top) cur_row--;
        end
      end else if (ch == CH_CR) begin
        cur_col = rg.left;
      end else if (ch == CH_LF) begin
        cur_col = rg.left;
        cur_row++;
      end else if (ch == CH_TAB) begin
        cur_col += TAB_STEP - (cur_col % TAB_STEP);
      end else if (ch >= PRINT_FIRST && ch <= PRINT_LAST) begin
        if (cur_col < SCREEN_COLS && cur_row < SCREEN_LINES) begin
          idx = cur_row * SCREEN_COLS + cur_col;
          screen_cells[idx] = (screen_cells[idx] & ATTR_MASK) | {8'h00, ch};
        end
        cur_col++;
      end
      if (cur_col >= rg.left + rg.w) begin
        cur_col = rg.left;
        cur_row++;
      end
      if (cur_row >= rg.top + rg.h) begin
        if (reg_scroll) begin
          for (int r = rg.top; r + 1 < rg.top + rg.h; r++)
            for (int c = rg.left; c < rg.left + rg.w; c++)
              screen_cells[r * SCREEN_COLS + c] = screen_cells[(r + 1) * SCREEN_COLS + c];
          for (int c = rg.left; c < rg.left + rg.w; c++) begin
            idx = (rg.top + rg.h - 1) * SCREEN_COLS + c;
            screen_cells[idx] = (screen_cells[idx] & ATTR_MASK) | {8'h00, SPACE_CHAR};
          end
          res.scrolled = 1'b1;
        end
        cur_row = rg.top + rg.h - 1;
      end
    end
    res.col = 7'(cur_col);
    res.row = 5'(cur_row);
    return res;
  endfunction

  function automatic console_result_t outcome(int col, int row, logic scrolled,
                                              logic [DATA_W-1:0] data);
    console_result_t res;
    res.col = 7'(col);
    res.row = 5'(row);
    res.scrolled = scrolled;
    res.data = data;
    return res;
  endfunction

  function automatic void add_item(logic op, logic [CH_W-1:0] ch, logic [ADDR_IN_W-1:0] addr,
                                   logic known, console_result_t want);
    stim_row_t row;
    row = '{kind: ROW_ITEM, op: op, ch: ch, addr: addr, known: known, want: want,
            left: '0, top: '0, width: '0, height: '0, scroll: 1'b0};
    stim_table.push_back(row);
  endfunction

  function automatic void add_regs(int left, int top, int width, int height, logic scroll);
    stim_row_t row;
    row = '{kind: ROW_REGS, op: OP_PUT, ch: '0, addr: '0, known: 1'b0, want: '0,
            left: 7'(left), top: 7'(top), width: 7'(width), height: 7'(height),
            scroll: scroll};
    stim_table.push_back(row);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic offer_item(logic op, logic [CH_W-1:0] ch, logic [ADDR_IN_W-1:0] addr,
                            logic known, console_result_t want);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.character <= ch;
    in_ch.cell_address <= addr;
    typed_pending = known;
    typed_want = want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain_and_configure(logic [CFG_DATA_W-1:0] left, logic [CFG_DATA_W-1:0] top,
                                     logic [CFG_DATA_W-1:0] width,
                                     logic [CFG_DATA_W-1:0] height, logic scroll);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (console_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_LEFT;
    cfg_data <= left;
    @(negedge clk);
    cfg_index <= REG_TOP;
    cfg_data <= top;
    @(negedge clk);
    cfg_index <= REG_WIDTH;
    cfg_data <= width;
    @(negedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data <= height;
    @(negedge clk);
    cfg_index <= REG_SCROLL;
    cfg_data <= {6'd0, scroll};
    @(negedge clk);
    cfg_we <= 1'b0;
    // let the registered home request move the cursor
    repeat (2) @(negedge clk);
  endtask

  // result checking, prediction and register tracking
  always @(posedge clk) begin : scoreboard
    console_result_t got;
    console_result_t want;
    console_result_t predicted;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got = outcome(out_ch.cursor_column, out_ch.cursor_line, out_ch.did_scroll,
                      out_ch.cell_data);
        if (console_results_q.size() == 0) begin
          $error("result item with none expected: col %0d line %0d scroll %0b data %h",
                 got.col, got.row, got.scrolled, got.data);
          error_count++;
        end else begin
          want = console_results_q.pop_front();
          if (got.col !== want.col) begin
            $error("cursor_column: expected %0d, got %0d", want.col, got.col);
            error_count++;
          end
          if (got.row !== want.row) begin
            $error("cursor_line: expected %0d, got %0d", want.row, got.row);
            error_count++;
          end
          if (got.scrolled !== want.scrolled) begin
            $error("did_scroll: expected %0b, got %0b", want.scrolled, got.scrolled);
            error_count++;
          end
          if (got.data !== want.data) begin
            $error("cell_data: expected %h, got %h", want.data, got.data);
            error_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted = advance_console(in_ch.operation, in_ch.character, in_ch.cell_address);
        console_results_q.push_back(typed_pending ? typed_want : predicted);
      end
      if (cfg_we) write_console_reg(cfg_index, cfg_data);
    end
  end

  // result side: choppy and clean stretches, random stalls, one long hold-off under load
  initial begin : result_stall
    int  seg_len;
    bit  choppy;
    bit  pressure_done;
    pressure_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      if (!pressure_done && results_seen >= PRESSURE_AFTER && in_ch.valid) begin
        pressure_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(250, 400)) @(negedge clk);
      end else if ($urandom_range(0, 40) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end else begin
        seg_len = $urandom_range(8, 64);
        choppy = ($urandom_range(0, 2) != 0);
        repeat (seg_len) begin
          out_ch.ready <= choppy ? ($urandom_range(0, 3) != 0) : 1'b1;
          @(negedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    region_t          rg;
    stim_row_t        row;
    logic             op;
    logic [CH_W-1:0]  ch;
    logic [ADDR_IN_W-1:0] addr;
    logic [CFG_DATA_W-1:0] left, top, width, height;
    logic             scroll;
    int               sel;
    int               lf_pct;

    reset_console();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_PUT;
    in_ch.character <= '0;
    in_ch.cell_address <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_LEFT;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset contents, out-of-range reads, every byte class, edge wraps
    add_item(OP_READ, 8'h00, 11'd0, 1'b1, outcome(0, 0, 1'b0, BLANK_CELL));
    add_item(OP_READ, 8'hFF, 11'd1999, 1'b1, outcome(0, 0, 1'b0, BLANK_CELL));
    add_item(OP_READ, 8'h00, 11'd2047, 1'b1, outcome(0, 0, 1'b0, 16'h0000));
    add_item(OP_READ, 8'h00, 11'd2000, 1'b1, outcome(0, 0, 1'b0, 16'h0000));
    add_item(OP_PUT, 8'h41, 11'd2047, 1'b1, outcome(1, 0, 1'b0, 16'h0000));
    add_item(OP_READ, 8'h00, 11'd0, 1'b1, outcome(1, 0, 1'b0, 16'h0741));
    add_item(OP_PUT, PRINT_LAST, 11'd0, 1'b1, outcome(2, 0, 1'b0, 16'h0000));
    add_item(OP_PUT, PRINT_FIRST, 11'd0, 1'b1, outcome(3, 0, 1'b0, 16'h0000));
    add_item(OP_PUT, 8'h1F, 11'd0, 1'b1, outcome(3, 0, 1'b0, 16'h0000));
    add_item(OP_PUT, 8'h80, 11'd0, 1'b1, outcome(3, 0, 1'b0, 16'h0000));
    add_item(OP_PUT, 8'hFF, 11'd0, 1'b1, outcome(3, 0, 1'b0, 16'h0000));
    add_item(OP_PUT, CH_TAB, 11'd0, 1'b1, outcome(8, 0, 1'b0, 16'h0000));
    add_item(OP_PUT, CH_BS, 11'd0, 1'b1, outcome(7, 0, 1'b0, 16'h0000));
    add_item(OP_PUT, CH_CR, 11'd0, 1'b1, outcome(0, 0, 1'b0, 16'h0000));
    add_item(OP_PUT, CH_BS, 11'd0, 1'b1, outcome(79, 0, 1'b0, 16'h0000));
    add_item(OP_PUT, 8'h78, 11'd0, 1'b1, outcome(0, 1, 1'b0, 16'h0000));
    add_item(OP_PUT, CH_LF, 11'd0, 1'b1, outcome(0, 2, 1'b0, 16'h0000));
    add_item(OP_PUT, CH_BS, 11'd0, 1'b1, outcome(79, 1, 1'b0, 16'h0000));
    add_item(OP_PUT, CH_TAB, 11'd0, 1'b1, outcome(0, 2, 1'b0, 16'h0000));
    add_item(OP_READ, 8'h00, 11'd79, 1'b1, outcome(0, 2, 1'b0, 16'h0778));
    // clamped 2x2 region at the bottom right: clamp, then scroll
    add_regs(78, 23, 127, 31, 1'b0);
    add_item(OP_PUT, 8'h61, 11'd0, 1'b0, '0);
    add_item(OP_PUT, 8'h62, 11'd0, 1'b0, '0);
    add_item(OP_PUT, CH_LF, 11'd0, 1'b0, '0);
    add_regs(78, 23, 127, 31, 1'b1);
    add_item(OP_PUT, CH_LF, 11'd0, 1'b0, '0);
    add_item(OP_PUT, CH_LF, 11'd0, 1'b0, '0);
    add_item(OP_READ, 8'h00, 11'd1918, 1'b0, '0);
    // out-of-range registers: one-cell region in the last cell
    add_regs(127, 31, 0, 0, 1'b1);
    add_item(OP_PUT, 8'h7A, 11'd0, 1'b0, '0);
    add_item(OP_READ, 8'h00, 11'd1999, 1'b0, '0);
    add_item(OP_PUT, CH_TAB, 11'd0, 1'b0, '0);

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.kind == ROW_REGS)
        drain_and_configure(row.left, row.top, row.width, row.height, row.scroll);
      else
        offer_item(row.op, row.ch, row.addr, row.known, row.want);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin left = 0;   top = 0;  width = 80;  height = 25; scroll = 1'b1; end
        1: begin left = 127; top = 31; width = 127; height = 31; scroll = 1'b0; end
        2: begin left = 0;   top = 0;  width = 1;   height = 1;  scroll = 1'b1; end
        3: begin left = 72;  top = 20; width = 8;   height = 5;  scroll = 1'b1; end
        default: begin
          scroll = $urandom_range(0, 1);
          left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 79);
          top = $urandom_range(0, 31);
          // scrolls of big regions are slow, keep them small
          width = scroll ? $urandom_range(0, 12) : $urandom_range(0, 127);
          height = scroll ? $urandom_range(0, 6) : $urandom_range(0, 31);
        end
      endcase
      drain_and_configure(left, top, width, height, scroll);
      rg = active_region();
      lf_pct = (p == 0) ? 30 : 3;
      repeat (PHASE_ITEMS) begin
        op = OP_PUT;
        ch = $urandom_range(0, 255);
        addr = $urandom_range(0, 2047);
        sel = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < lf_pct) begin
          ch = CH_LF;
        end else if (sel < 55) begin
          ch = $urandom_range(PRINT_FIRST, PRINT_LAST);
        end else if (sel < 72) begin
          case ($urandom_range(0, 3))
            0: ch = CH_LF;
            1: ch = CH_CR;
            2: ch = CH_BS;
            default: ch = CH_TAB;
          endcase
        end else if (sel < 90 && sel >= 80) begin
          op = OP_READ;
          addr = 11'((rg.top + $urandom_range(0, rg.h - 1)) * SCREEN_COLS
                     + rg.left + $urandom_range(0, rg.w - 1));
        end else if (sel >= 90) begin
          op = OP_READ;
        end
        offer_item(op, ch, addr, 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (console_results_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
